// ----- hdl/hmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hmsc_pkg
// Types, codes and decode helpers for the six-digit clock display scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package hmsc_pkg;

   localparam int HOURS_W   = 5;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;
   localparam int KIND_W    = 2;
   localparam int MODE_W    = 2;
   localparam int POS_W     = 3;
   localparam int DIGIT_W   = 4;
   localparam int SEG_W     = 8;

   localparam logic [KIND_W-1:0] KIND_SECOND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_12H = 2'd0;
   localparam logic [MODE_W-1:0] MODE_24H = 2'd1;

   localparam logic [HOURS_W-1:0]   HOUR_LIMIT_12H   = 5'd12;
   localparam logic [HOURS_W-1:0]   HOUR_LIMIT_24H   = 5'd24;
   localparam logic [MINUTES_W-1:0] UNITS_PER_MINUTE = 6'd60;

   localparam logic [POS_W-1:0] POS_SEC_UNITS  = 3'd0;
   localparam logic [POS_W-1:0] POS_SEC_TENS   = 3'd1;
   localparam logic [POS_W-1:0] POS_MIN_UNITS  = 3'd2;
   localparam logic [POS_W-1:0] POS_MIN_TENS   = 3'd3;
   localparam logic [POS_W-1:0] POS_HOUR_UNITS = 3'd4;
   localparam logic [POS_W-1:0] POS_HOUR_TENS  = 3'd5;

   localparam logic [SEG_W-1:0] SELECT_FIRST = 8'h80;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [HOURS_W-1:0]   set_hours;
      logic [MINUTES_W-1:0] set_minutes;
      logic [SECONDS_W-1:0] set_seconds;
   } req_type;

   typedef struct packed {
      logic [SEG_W-1:0]     digit_select;
      logic [SEG_W-1:0]     segment_pattern;
      logic [HOURS_W-1:0]   hours_now;
      logic [MINUTES_W-1:0] minutes_now;
      logic [SECONDS_W-1:0] seconds_now;
      logic                 load_rejected;
   } rsp_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
   } digits_type;

   // Decimal split of a value below 64.
   function automatic digits_type split_digits(input logic [5:0] value);
      digits_type d;
      logic [5:0] base;
      if (value >= 6'd60) begin
         d.tens = 4'd6; base = 6'd60;
      end else if (value >= 6'd50) begin
         d.tens = 4'd5; base = 6'd50;
      end else if (value >= 6'd40) begin
         d.tens = 4'd4; base = 6'd40;
      end else if (value >= 6'd30) begin
         d.tens = 4'd3; base = 6'd30;
      end else if (value >= 6'd20) begin
         d.tens = 4'd2; base = 6'd20;
      end else if (value >= 6'd10) begin
         d.tens = 4'd1; base = 6'd10;
      end else begin
         d.tens = 4'd0; base = 6'd0;
      end
      d.units = 4'(value - base);
      return d;
   endfunction

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pat;
      case (digit)
         4'd0: pat = 8'b11111100;
         4'd1: pat = 8'b01100000;
         4'd2: pat = 8'b11011010;
         4'd3: pat = 8'b11110010;
         4'd4: pat = 8'b01100110;
         4'd5: pat = 8'b10110110;
         4'd6: pat = 8'b10111110;
         4'd7: pat = 8'b11100000;
         4'd8: pat = 8'b11111110;
         4'd9: pat = 8'b11110110;
         default: pat = 8'b00000000;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hms_clock_seven_segment_scan.sv -----
// ----------------------------------------------------------------------------
// hms_clock_seven_segment_scan
// Time-of-day counter with a six-digit multiplexed seven-segment scan.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the result is not stalled; each produces
// exactly one result: the input register holds the transaction and the result
// register captures a single pass of counter, compare and segment-decode logic.
// A stalled result holds the input register and stalls the request side. Kind 0
// is a one-second tick, kind 1 a scan tick that shows the next digit (second
// units first, hour tens last), kind 2 loads the time. The mode register is to be
// written through the csr port only while no transaction is in flight; the block
// does not enforce this. Mode 2 or 3 blanks the display, stops counting and
// rejects every load.
`default_nettype none

module hms_clock_seven_segment_scan (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire hmsc_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      hmsc_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [hmsc_pkg::MODE_W-1:0]    csr_data
);

   logic                                in_valid_ff;
   hmsc_pkg::req_type                   in_data_ff;
   logic                                rsp_valid_ff;
   hmsc_pkg::rsp_type                   rsp_data_ff;
   hmsc_pkg::rsp_type                   rsp_data_in;
   logic [hmsc_pkg::MODE_W-1:0]         mode_ff;
   logic [hmsc_pkg::HOURS_W-1:0]        hours_ff, hours_in;
   logic [hmsc_pkg::MINUTES_W-1:0]      minutes_ff, minutes_in;
   logic [hmsc_pkg::SECONDS_W-1:0]      seconds_ff, seconds_in;
   logic [hmsc_pkg::POS_W-1:0]          pos_ff, pos_in;

   logic                                out_free;
   logic                                advance;
   logic                                mode_ok;
   logic [hmsc_pkg::HOURS_W-1:0]        limit;
   logic [hmsc_pkg::POS_W-1:0]          pos_eff;
   logic [hmsc_pkg::SECONDS_W-1:0]      sec_inc;
   logic [hmsc_pkg::MINUTES_W-1:0]      min_step;
   logic [hmsc_pkg::HOURS_W-1:0]        hour_step;
   hmsc_pkg::digits_type                sec_digits, min_digits, hour_digits;
   logic [hmsc_pkg::DIGIT_W-1:0]        digit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      unique case (mode_ff)
         hmsc_pkg::MODE_12H: begin
            limit = hmsc_pkg::HOUR_LIMIT_12H; mode_ok = 1'b1;
         end
         hmsc_pkg::MODE_24H: begin
            limit = hmsc_pkg::HOUR_LIMIT_24H; mode_ok = 1'b1;
         end
         default: begin
            limit = '0; mode_ok = 1'b0;
         end
      endcase
   end

   assign pos_eff     = (pos_ff > hmsc_pkg::POS_HOUR_TENS) ? hmsc_pkg::POS_SEC_UNITS : pos_ff;
   assign sec_digits  = hmsc_pkg::split_digits(seconds_ff);
   assign min_digits  = hmsc_pkg::split_digits(minutes_ff);
   assign hour_digits = hmsc_pkg::split_digits({1'b0, hours_ff});
   assign sec_inc     = seconds_ff + 6'd1;

   always_comb begin
      unique case (pos_eff)
         hmsc_pkg::POS_SEC_UNITS:  digit = sec_digits.units;
         hmsc_pkg::POS_SEC_TENS:   digit = sec_digits.tens;
         hmsc_pkg::POS_MIN_UNITS:  digit = min_digits.units;
         hmsc_pkg::POS_MIN_TENS:   digit = min_digits.tens;
         hmsc_pkg::POS_HOUR_UNITS: digit = hour_digits.units;
         default:                  digit = hour_digits.tens;
      endcase
   end

   always_comb begin
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      pos_in     = pos_ff;
      min_step   = minutes_ff;
      hour_step  = hours_ff;
      rsp_data_in.digit_select    = '0;
      rsp_data_in.segment_pattern = '0;
      rsp_data_in.load_rejected   = 1'b0;

      unique case (in_data_ff.kind)
         hmsc_pkg::KIND_SECOND: begin
            if (mode_ok) begin
               if (sec_inc >= hmsc_pkg::UNITS_PER_MINUTE) begin
                  seconds_in = '0;
                  min_step   = minutes_ff + 6'd1;
               end else begin
                  seconds_in = sec_inc;
               end
               if (min_step >= hmsc_pkg::UNITS_PER_MINUTE) begin
                  minutes_in = '0;
                  hour_step  = hours_ff + 5'd1;
               end else begin
                  minutes_in = min_step;
               end
               hours_in = (hour_step >= limit) ? '0 : hour_step;
            end
         end
         hmsc_pkg::KIND_SCAN: begin
            if (mode_ok) begin
               rsp_data_in.digit_select    = hmsc_pkg::SELECT_FIRST >> pos_eff;
               rsp_data_in.segment_pattern = hmsc_pkg::seg_pattern(digit);
               pos_in = (pos_eff == hmsc_pkg::POS_HOUR_TENS) ?
                        hmsc_pkg::POS_SEC_UNITS : pos_eff + 3'd1;
            end
         end
         hmsc_pkg::KIND_LOAD: begin
            if (!mode_ok || in_data_ff.set_hours >= limit ||
                in_data_ff.set_minutes >= hmsc_pkg::UNITS_PER_MINUTE ||
                in_data_ff.set_seconds >= hmsc_pkg::UNITS_PER_MINUTE) begin
               rsp_data_in.load_rejected = 1'b1;
            end else begin
               hours_in   = in_data_ff.set_hours;
               minutes_in = in_data_ff.set_minutes;
               seconds_in = in_data_ff.set_seconds;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.hours_now   = hours_in;
      rsp_data_in.minutes_now = minutes_in;
      rsp_data_in.seconds_now = seconds_in;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // result register and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hours_ff     <= '0;
         minutes_ff   <= '0;
         seconds_ff   <= '0;
         pos_ff       <= hmsc_pkg::POS_SEC_UNITS;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            hours_ff   <= hours_in;
            minutes_ff <= minutes_in;
            seconds_ff <= seconds_in;
            pos_ff     <= pos_in;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hmsc_pkg::MODE_12H;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

endmodule

`default_nettype wire
